FILE: rtl/core/tcp_congestion_window_control_defines.svh
// Assertion macros shared by the congestion window control RTL.
// No dependencies; pulled in by the files that carry assertions.
`ifndef TCP_CONGESTION_WINDOW_CONTROL_DEFINES_SVH
`define TCP_CONGESTION_WINDOW_CONTROL_DEFINES_SVH

// Clocked property with an explicit clock and active-low reset.
`define TCWC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property on the block clock and reset.
`define TCWC_ASSERT(lbl, prop, msg) `TCWC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/core/tcwc_pkg.sv
// Types, constants and helper functions of the congestion window control block.
// No dependencies; imported by tcwc_divider and tcp_congestion_window_control.
package tcwc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SEG_W     = 16;
    localparam int unsigned THR_W     = 8;
    localparam int unsigned DUP_W     = 8;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic [WORD_W-1:0] t_word;

    // Event codes
    localparam logic [ACT_W-1:0] ACT_CONN_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_HANDSHAKE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK        = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUPACK_THRESHOLD = 2'd1;

    localparam logic [SEG_W-1:0] SEG_RESET = 16'd536;
    localparam logic [THR_W-1:0] THR_RESET = 8'd3;

    localparam t_word START_THRESHOLD = 32'd1072;
    localparam t_word IW_HALF         = 32'd2190;
    localparam t_word IW_QUARTER      = 32'd1095;
    localparam t_word ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [DUP_W-1:0] DUP_MAX = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LAUNCH,
        S_WAIT,
        S_GROW,
        S_POST
    } t_state;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
    } t_div_rsp;

    // Add with saturation at all ones
    function automatic t_word sat_add(input t_word a, input t_word b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? ALL_ONES : s[WORD_W-1:0];
    endfunction

    // a at or before b, modulo 2^32
    function automatic logic seq_lte(input t_word a, input t_word b);
        t_word d;
        d = a - b;
        return (d == '0) || d[WORD_W-1];
    endfunction

    // Initial window: 2, 3 or 4 segments
    function automatic t_word initial_window(input logic [SEG_W-1:0] seg);
        t_word s;
        s = {{(WORD_W-SEG_W){1'b0}}, seg};
        if (s > IW_HALF) begin
            return s << 1;
        end else if (s > IW_QUARTER) begin
            return (s << 1) + s;
        end
        return s << 2;
    endfunction

endpackage

FILE: rtl/core/tcp_congestion_window_control.sv
// From accept, an event passes S_EXEC and S_POST into the output register; an ack that grows
// the window in congestion avoidance also passes S_LAUNCH, S_WAIT (32-step serial divide of
// segment size squared by window) and S_GROW. One event is in work at a time; a new request
// is taken while the previous result waits in the output register.
// Synchronous active-low reset clears the congestion state to zero and the segment size
// and duplicate threshold registers to 536 and 3; no clearing pass.
`include "tcp_congestion_window_control_defines.svh"

module tcp_congestion_window_control (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tcwc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcwc_pkg::SEG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [tcwc_pkg::ACT_W-1:0]           i_action,
    input  logic [tcwc_pkg::WORD_W-1:0]          i_ack_number,
    input  logic [tcwc_pkg::WORD_W-1:0]          i_send_next,
    input  logic [tcwc_pkg::WORD_W-1:0]          i_peer_window,
    input  logic [tcwc_pkg::WORD_W-1:0]          i_unacked_bytes,
    input  logic                                 i_timer_running,
    input  logic                                 i_established,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tcwc_pkg::WORD_W-1:0]          o_window_now,
    output logic [tcwc_pkg::WORD_W-1:0]          o_threshold_now,
    output logic [tcwc_pkg::DUP_W-1:0]           o_dupacks_now,
    output logic                                 o_retransmit_flag,
    output logic                                 o_recovery_flag,
    output logic [tcwc_pkg::WORD_W-1:0]          o_recover_point
);
    import tcwc_pkg::*;

    t_state r_state, n_state;

    // Configuration
    logic [SEG_W-1:0] r_seg_size;
    logic [THR_W-1:0] r_dup_thr;

    // Captured request
    logic [ACT_W-1:0] r_action;
    t_word            r_ack, r_snd, r_pwin, r_unacked;
    logic             r_timer, r_est;

    // Congestion state
    t_word            r_cong_window, n_cong_window;
    t_word            r_ss_threshold, n_ss_threshold;
    logic [DUP_W-1:0] r_dup_count, n_dup_count;
    t_word            r_highest_ack, n_highest_ack;
    t_word            r_recovery_seq, n_recovery_seq;
    t_word            r_window_cap, n_window_cap;
    logic             r_retx_pending, n_retx_pending;
    logic             r_recovering, n_recovering;

    t_word            r_square;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic             n_out_load;
    t_word            r_out_window, r_out_threshold, r_out_recover;
    logic [DUP_W-1:0] r_out_dupacks;
    logic             r_out_retx, r_out_recovery;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic             w_in_accept;
    t_word            w_seg, w_two_seg, w_iw, w_acked, w_half, w_rec_thr;
    t_word            w_cw_plus_seg, w_cw_base, w_ss_inc, w_q_inc, w_grow_sum;
    t_word            w_square;
    logic             w_ack_old, w_ack_dup, w_ack_in_flight, w_rec_end;
    logic [DUP_W-1:0] w_dup_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Event arithmetic on the captured request
    assign w_seg           = {{(WORD_W-SEG_W){1'b0}}, r_seg_size};
    assign w_two_seg       = w_seg << 1;
    assign w_iw            = initial_window(r_seg_size);
    assign w_square        = WORD_W'(r_seg_size) * WORD_W'(r_seg_size);
    assign w_acked         = r_ack - r_highest_ack;
    assign w_ack_old       = (w_acked == '0) || w_acked[WORD_W-1];
    assign w_ack_dup       = r_timer && (r_ack == r_highest_ack);
    assign w_dup_inc       = (r_dup_count != DUP_MAX) ? r_dup_count + 1'b1 : r_dup_count;
    assign w_ack_in_flight = seq_lte(r_ack, r_snd);
    assign w_rec_end       = r_recovering && !seq_lte(r_ack, r_recovery_seq);
    assign w_cw_base       = w_rec_end ? r_ss_threshold : r_cong_window;
    assign w_half          = r_unacked >> 1;
    assign w_rec_thr       = (w_half > w_two_seg) ? w_half : w_two_seg;
    assign w_cw_plus_seg   = sat_add(r_cong_window, w_seg);
    assign w_ss_inc        = ((w_acked != '0) && (w_acked < w_seg)) ? w_acked : w_seg;
    assign w_q_inc         = (div_rsp.quotient > 32'd1) ? div_rsp.quotient : 32'd1;
    assign w_grow_sum      = sat_add(r_cong_window, w_q_inc);

    // Divide segment size squared by the window
    assign div_req.start    = (r_state == S_LAUNCH);
    assign div_req.dividend = r_square;
    assign div_req.divisor  = r_cong_window;

    tcwc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer: next state and state updates
    always_comb begin
        n_state        = r_state;
        n_cong_window  = r_cong_window;
        n_ss_threshold = r_ss_threshold;
        n_dup_count    = r_dup_count;
        n_highest_ack  = r_highest_ack;
        n_recovery_seq = r_recovery_seq;
        n_window_cap   = r_window_cap;
        n_retx_pending = r_retx_pending;
        n_recovering   = r_recovering;
        n_out_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_POST;
                case (r_action)
                    ACT_CONN_START: begin
                        n_cong_window  = w_iw;
                        n_ss_threshold = START_THRESHOLD;
                        n_dup_count    = '0;
                    end
                    ACT_HANDSHAKE: begin
                        if (r_retx_pending) begin
                            n_ss_threshold = w_rec_thr;
                            n_cong_window  = sat_add(w_rec_thr, w_two_seg + w_seg);
                            n_retx_pending = 1'b0;
                            n_recovering   = 1'b1;
                        end else begin
                            n_highest_ack = r_ack;
                            n_cong_window = w_iw;
                            n_window_cap  = r_pwin;
                            if (r_pwin > r_ss_threshold) begin
                                n_ss_threshold = r_pwin;
                            end
                        end
                    end
                    ACT_ACK: begin
                        if (w_ack_old) begin
                            // count duplicates, inflate, flag fast retransmit
                            if (w_ack_dup) begin
                                n_dup_count = w_dup_inc;
                                if (w_dup_inc > r_dup_thr) begin
                                    n_cong_window = w_cw_plus_seg;
                                end
                                if (w_dup_inc >= r_dup_thr) begin
                                    n_retx_pending = 1'b1;
                                    n_recovery_seq = r_snd;
                                end
                            end
                        end else if (w_ack_in_flight) begin
                            n_dup_count   = '0;
                            n_highest_ack = r_ack;
                            if (r_recovering && !w_rec_end) begin
                                n_cong_window = w_cw_plus_seg;
                            end else begin
                                n_recovering  = 1'b0;
                                n_cong_window = w_cw_base;
                                if (r_est) begin
                                    if (w_cw_base < r_ss_threshold) begin
                                        n_cong_window = sat_add(w_cw_base, w_ss_inc);
                                    end else if (w_cw_base == '0) begin
                                        n_cong_window = (r_window_cap < 32'd1) ?
                                                        r_window_cap : 32'd1;
                                    end else begin
                                        n_state = S_LAUNCH;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                n_cong_window = (w_grow_sum > r_window_cap) ? r_window_cap : w_grow_sum;
                n_state       = S_POST;
            end
            S_POST: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (n_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State, configuration and congestion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_seg_size     <= SEG_RESET;
            r_dup_thr      <= THR_RESET;
            r_cong_window  <= '0;
            r_ss_threshold <= '0;
            r_dup_count    <= '0;
            r_highest_ack  <= '0;
            r_recovery_seq <= '0;
            r_window_cap   <= '0;
            r_retx_pending <= 1'b0;
            r_recovering   <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_cong_window  <= n_cong_window;
            r_ss_threshold <= n_ss_threshold;
            r_dup_count    <= n_dup_count;
            r_highest_ack  <= n_highest_ack;
            r_recovery_seq <= n_recovery_seq;
            r_window_cap   <= n_window_cap;
            r_retx_pending <= n_retx_pending;
            r_recovering   <= n_recovering;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SEGMENT_SIZE:     r_seg_size <= i_cfg_data;
                    CFG_DUPACK_THRESHOLD: r_dup_thr  <= i_cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture the request, the square and the result payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_action  <= i_action;
            r_ack     <= i_ack_number;
            r_snd     <= i_send_next;
            r_pwin    <= i_peer_window;
            r_unacked <= i_unacked_bytes;
            r_timer   <= i_timer_running;
            r_est     <= i_established;
        end
        if (r_state == S_EXEC) begin
            r_square <= w_square;
        end
        if (n_out_load) begin
            r_out_window    <= r_cong_window;
            r_out_threshold <= r_ss_threshold;
            r_out_dupacks   <= r_dup_count;
            r_out_retx      <= r_retx_pending;
            r_out_recovery  <= r_recovering;
            r_out_recover   <= r_recovery_seq;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_window_now      = r_out_window;
    assign o_threshold_now   = r_out_threshold;
    assign o_dupacks_now     = r_out_dupacks;
    assign o_retransmit_flag = r_out_retx;
    assign o_recovery_flag   = r_out_recovery;
    assign o_recover_point   = r_out_recover;

    `TCWC_ASSERT(a_div_done_in_wait, div_rsp.done |-> (r_state == S_WAIT), "stray divide done")
    `TCWC_ASSERT(a_out_from_post, $rose(r_out_valid) |-> ($past(r_state) == S_POST), "bad load")
    `TCWC_ASSERT(a_dup_from_exec, !$stable(r_dup_count) |-> ($past(r_state) == S_EXEC), "dup cnt")

endmodule

FILE: rtl/core/tcwc_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tcwc_pkg and tcp_congestion_window_control_defines.svh.
`include "tcp_congestion_window_control_defines.svh"

module tcwc_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcwc_pkg::t_div_req i_req,
    output tcwc_pkg::t_div_rsp o_rsp
);
    import tcwc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    t_word                r_rem, n_rem;
    t_word                r_quo, n_quo;
    t_word                r_dsr, n_dsr;
    logic [WORD_W:0]      w_shifted;
    logic [WORD_W:0]      w_diff;

    // Shift in the next dividend bit and trial-subtract
    assign w_shifted = {r_rem, r_quo[WORD_W-1]};
    assign w_diff    = w_shifted - {1'b0, r_dsr};

    // Step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[WORD_W]) begin
                n_rem = w_diff[WORD_W-1:0];
                n_quo = {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                n_rem = w_shifted[WORD_W-1:0];
                n_quo = {r_quo[WORD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `TCWC_ASSERT(a_no_start_while_busy, i_req.start |-> !r_busy, "divider restarted mid-run")
    `TCWC_ASSERT(a_rem_below_divisor, r_busy |-> (r_rem < r_dsr), "partial remainder overflow")
    `TCWC_ASSERT(a_done_after_busy, r_done |-> $past(r_busy), "done without a run")

endmodule

FILE: sim/tb_tcp_congestion_window_control.sv
// Self-checking testbench for tcp_congestion_window_control: directed events, then random
// connection lifecycles under several register settings and handshake idling patterns.
// Depends on tcwc_pkg and the tcp_congestion_window_control RTL.
module tb_tcp_congestion_window_control;
    import tcwc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int STORM_PHASE     = 1;
    localparam int PAUSE_PHASE     = 3;
    localparam int HOLD_PHASE      = 4;
    localparam int STORM_LENGTH    = 270;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 500000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [ACT_W-1:0] action;
        t_word            ack;
        t_word            snd;
        t_word            pwin;
        t_word            unacked;
        logic             timer;
        logic             est;
    } t_cc_event;

    typedef struct {
        t_word            window;
        t_word            threshold;
        logic [DUP_W-1:0] dupacks;
        logic             retransmit;
        logic             recovery;
        t_word            recover_point;
    } t_cc_report;

    // Predict congestion state per accepted request and check reports in order
    class cwnd_tracker;
        logic [SEG_W-1:0] seg_size    = SEG_RESET;
        logic [THR_W-1:0] dup_limit   = THR_RESET;
        t_word            cwnd        = '0;
        t_word            ssthresh    = '0;
        t_word            last_ack    = '0;
        t_word            recover_seq = '0;
        t_word            cap         = '0;
        logic [DUP_W-1:0] dupacks     = '0;
        logic             rtx_pending = 1'b0;
        logic             in_recovery = 1'b0;
        t_cc_report       expected_reports[$];
        int unsigned      mismatch_count = 0;

        function t_word add_sat(t_word a, t_word b);
            t_word s;
            s = a + b;
            return (s < a) ? ALL_ONES : s;
        endfunction

        function bit at_or_before(t_word a, t_word b);
            t_word d;
            d = a - b;
            return (d == '0) || d[WORD_W-1];
        endfunction

        // 2, 3 or 4 segments depending on segment size
        function t_word start_window();
            t_word s;
            s = t_word'(seg_size);
            if (s > IW_HALF) begin
                return 2 * s;
            end else if (s > IW_QUARTER) begin
                return 3 * s;
            end
            return 4 * s;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] data);
            if (idx == CFG_SEGMENT_SIZE) begin
                seg_size = data;
            end else if (idx == CFG_DUPACK_THRESHOLD) begin
                dup_limit = data[THR_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void note_event(t_cc_event ev);
            t_word      seg32;
            t_word      half;
            t_word      two;
            t_word      acked;
            t_word      inc;
            t_word      q;
            bit         grow;
            t_cc_report want;
            seg32 = t_word'(seg_size);
            case (ev.action)
                ACT_CONN_START: begin
                    cwnd = start_window();
                    ssthresh = START_THRESHOLD;
                    dupacks = '0;
                end
                ACT_HANDSHAKE: begin
                    if (rtx_pending) begin
                        // enter fast recovery
                        half = ev.unacked >> 1;
                        two = 2 * seg32;
                        ssthresh = (half > two) ? half : two;
                        cwnd = add_sat(ssthresh, 3 * seg32);
                        rtx_pending = 1'b0;
                        in_recovery = 1'b1;
                    end else begin
                        last_ack = ev.ack;
                        cwnd = start_window();
                        cap = ev.pwin;
                        if (ev.pwin > ssthresh) ssthresh = ev.pwin;
                    end
                end
                ACT_ACK: begin
                    if (at_or_before(ev.ack, last_ack)) begin
                        // duplicate only with the timer running and an exact match
                        if (ev.timer && ev.ack == last_ack) begin
                            if (dupacks != DUP_MAX) dupacks = dupacks + 1'b1;
                            if (dupacks > dup_limit) cwnd = add_sat(cwnd, seg32);
                            if (dupacks >= dup_limit) begin
                                rtx_pending = 1'b1;
                                recover_seq = ev.snd;
                            end
                        end
                    end else if (at_or_before(ev.ack, ev.snd)) begin
                        acked = ev.ack - last_ack;
                        dupacks = '0;
                        last_ack = ev.ack;
                        grow = 1'b1;
                        if (in_recovery) begin
                            if (!at_or_before(ev.ack, recover_seq)) begin
                                in_recovery = 1'b0;
                                cwnd = ssthresh;
                            end else begin
                                cwnd = add_sat(cwnd, seg32);
                                grow = 1'b0;
                            end
                        end
                        if (grow && ev.est) begin
                            if (cwnd < ssthresh) begin
                                // slow start
                                inc = (acked != '0 && acked < seg32) ? acked : seg32;
                                cwnd = add_sat(cwnd, inc);
                            end else begin
                                // congestion avoidance, clamped to the peer window
                                inc = 1;
                                if (cwnd != '0) begin
                                    q = (seg32 * seg32) / cwnd;
                                    if (q > 1) inc = q;
                                end
                                cwnd = add_sat(cwnd, inc);
                                if (cwnd > cap) cwnd = cap;
                            end
                        end
                    end
                end
                default: ;
            endcase
            want.window = cwnd;
            want.threshold = ssthresh;
            want.dupacks = dupacks;
            want.retransmit = rtx_pending;
            want.recovery = in_recovery;
            want.recover_point = recover_seq;
            expected_reports.push_back(want);
        endfunction

        function void check_report(t_cc_report seen);
            t_cc_report want;
            if (expected_reports.size() == 0) begin
                $error("report with none expected: window_now %0d", seen.window);
                mismatch_count++;
                return;
            end
            want = expected_reports.pop_front();
            if (seen.window !== want.window) begin
                $error("window_now: expected %0d, actual %0d", want.window, seen.window);
                mismatch_count++;
            end
            if (seen.threshold !== want.threshold) begin
                $error("threshold_now: expected %0d, actual %0d", want.threshold,
                       seen.threshold);
                mismatch_count++;
            end
            if (seen.dupacks !== want.dupacks) begin
                $error("dupacks_now: expected %0d, actual %0d", want.dupacks, seen.dupacks);
                mismatch_count++;
            end
            if (seen.retransmit !== want.retransmit) begin
                $error("retransmit_flag: expected %0d, actual %0d", want.retransmit,
                       seen.retransmit);
                mismatch_count++;
            end
            if (seen.recovery !== want.recovery) begin
                $error("recovery_flag: expected %0d, actual %0d", want.recovery,
                       seen.recovery);
                mismatch_count++;
            end
            if (seen.recover_point !== want.recover_point) begin
                $error("recover_point: expected %0d, actual %0d", want.recover_point,
                       seen.recover_point);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_SEGMENT_SIZE;
    logic [SEG_W-1:0]     i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [ACT_W-1:0]     i_action        = ACT_CONN_START;
    t_word                i_ack_number    = '0;
    t_word                i_send_next     = '0;
    t_word                i_peer_window   = '0;
    t_word                i_unacked_bytes = '0;
    logic                 i_timer_running = 1'b0;
    logic                 i_established   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    t_word                o_window_now;
    t_word                o_threshold_now;
    logic [DUP_W-1:0]     o_dupacks_now;
    logic                 o_retransmit_flag;
    logic                 o_recovery_flag;
    t_word                o_recover_point;

    cwnd_tracker sb = new();
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    int unsigned rx_hold_cycles = 0;
    int unsigned cycle_count    = 0;

    logic [SEG_W-1:0] phase_seg [NUM_PHASES] =
        '{16'd1460, 16'd65535, 16'd1, 16'd2191, 16'd1096, 16'd0, 16'd2190, 16'd1095, 16'd536};
    logic [THR_W-1:0] phase_thr [NUM_PHASES] =
        '{8'd3, 8'd255, 8'd1, 8'd2, 8'd0, 8'd7, 8'd3, 8'd4, 8'd3};

    tcp_congestion_window_control uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_ack_number     (i_ack_number),
        .i_send_next      (i_send_next),
        .i_peer_window    (i_peer_window),
        .i_unacked_bytes  (i_unacked_bytes),
        .i_timer_running  (i_timer_running),
        .i_established    (i_established),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_window_now     (o_window_now),
        .o_threshold_now  (o_threshold_now),
        .o_dupacks_now    (o_dupacks_now),
        .o_retransmit_flag(o_retransmit_flag),
        .o_recovery_flag  (o_recovery_flag),
        .o_recover_point  (o_recover_point)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Check each accepted report, then drive the output stall
    always @(posedge i_clk) begin : result_monitor
        t_cc_report seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.window = o_window_now;
            seen.threshold = o_threshold_now;
            seen.dupacks = o_dupacks_now;
            seen.retransmit = o_retransmit_flag;
            seen.recovery = o_recovery_flag;
            seen.recover_point = o_recover_point;
            sb.check_report(seen);
        end
        if (rx_hold_cycles != 0) begin
            rx_hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Abort a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tcp_congestion_window_control: mismatch");
        $finish;
    end

    function automatic t_cc_event make_event(logic [ACT_W-1:0] action, t_word ack, t_word snd,
                                             t_word pwin, t_word unacked, logic timer,
                                             logic est);
        t_cc_event ev;
        ev.action = action;
        ev.ack = ack;
        ev.snd = snd;
        ev.pwin = pwin;
        ev.unacked = unacked;
        ev.timer = timer;
        ev.est = est;
        return ev;
    endfunction

    // Mostly well-formed acks around the current ack point, some noise
    function automatic t_cc_event random_event();
        t_cc_event   ev;
        t_word       seg1;
        t_word       span;
        int unsigned pick;
        seg1 = (sb.seg_size == '0) ? t_word'(1) : t_word'(sb.seg_size);
        ev = make_event(ACT_ACK, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(9) != 0, $urandom_range(9) != 0);
        case ($urandom_range(9))
            0: ev.pwin = '0;
            1: ev.pwin = ALL_ONES;
            2, 3, 4, 5: ev.pwin = $urandom_range(0, 200000);
            default: ;
        endcase
        pick = $urandom_range(99);
        if (sb.dupacks != '0 && sb.dupacks < sb.dup_limit && $urandom_range(1) == 1) pick = 60;
        if (pick < 5) begin
            ev.action = ACT_CONN_START;
        end else if (pick < 10 || (sb.rtx_pending && pick < 25)) begin
            ev.action = ACT_HANDSHAKE;
            if ($urandom_range(1) == 1) ev.unacked = $urandom_range(0, 8 * seg1);
            if ($urandom_range(3) == 0) ev.ack = sb.last_ack;
        end else if (pick < 50) begin
            // new data, partial acks while in recovery
            span = sb.recover_seq - sb.last_ack;
            if (sb.in_recovery && span != '0 && !span[WORD_W-1] && $urandom_range(2) != 0) begin
                ev.ack = sb.last_ack + $urandom_range(1, span);
            end else begin
                case ($urandom_range(3))
                    0: ev.ack = sb.last_ack + $urandom_range(1, seg1);
                    1: ev.ack = sb.last_ack + seg1;
                    2: ev.ack = sb.last_ack + $urandom_range(1, 4 * seg1);
                    default: ev.ack = sb.last_ack + $urandom_range(1, 1 << 20);
                endcase
            end
            ev.snd = ev.ack + $urandom_range(0, 8 * seg1);
        end else if (pick < 80) begin
            ev.ack = sb.last_ack;
            ev.snd = sb.last_ack + $urandom_range(0, 1 << 16);
        end else if (pick < 86) begin
            ev.ack = sb.last_ack - $urandom_range(1, 1 << 20);
        end else if (pick < 92) begin
            ev.snd = sb.last_ack + $urandom_range(0, 4 * seg1);
            ev.ack = ev.snd + $urandom_range(1, 1 << 20);
        end else if (pick < 95) begin
            ev.action = ACT_UNUSED;
        end else begin
            ev.action = ACT_W'($urandom_range(3));
        end
        return ev;
    endfunction

    // Offer one request after an optional idle gap; hold it until accepted
    task automatic send_event(input t_cc_event ev);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_action <= ev.action;
        i_ack_number <= ev.ack;
        i_send_next <= ev.snd;
        i_peer_window <= ev.pwin;
        i_unacked_bytes <= ev.unacked;
        i_timer_running <= ev.timer;
        i_established <= ev.est;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_event(ev);
    endtask

    // Drop valid and wait until every expected report has arrived
    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_config(input logic [SEG_W-1:0] seg, input logic [SEG_W-1:0] thr_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SEGMENT_SIZE;
        i_cfg_data <= seg;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(CFG_SEGMENT_SIZE, seg);
        i_cfg_index <= CFG_DUPACK_THRESHOLD;
        i_cfg_data <= thr_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(CFG_DUPACK_THRESHOLD, thr_word);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_idle_mode       mode;
        logic [SEG_W-1:0] thr_word;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events at the reset register values
        // zero window in congestion avoidance straight out of reset
        send_event(make_event(ACT_ACK, 32'h100, 32'h200, $urandom, $urandom, 1'b0, 1'b1));
        send_event(make_event(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_CONN_START, $urandom, $urandom, $urandom, $urandom, 1'b0,
                              1'b0));
        // ack point just below wrap, widest peer window
        send_event(make_event(ACT_HANDSHAKE, 32'hFFFF_FFF0, $urandom, ALL_ONES, $urandom, 1'b1,
                              1'b1));
        send_event(make_event(ACT_ACK, 32'h10, 32'h1000, $urandom, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_ACK, 32'h228, 32'h1000, $urandom, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_ACK, 32'h400, 32'h1000, $urandom, $urandom, 1'b1, 1'b0));
        // ack beyond send next, old ack, duplicate without timer
        send_event(make_event(ACT_ACK, 32'h2000, 32'h1000, $urandom, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_ACK, 32'h5, 32'h1000, $urandom, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_ACK, 32'h400, 32'h8000, $urandom, $urandom, 1'b0, 1'b1));
        repeat (4) send_event(make_event(ACT_ACK, 32'h400, 32'h8000, $urandom, $urandom, 1'b1,
                                         1'b1));
        send_event(make_event(ACT_HANDSHAKE, $urandom, $urandom, $urandom, ALL_ONES, 1'b1,
                              1'b1));
        send_event(make_event(ACT_ACK, 32'h4000, 32'h9000, $urandom, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_HANDSHAKE, 32'h4000, $urandom, ALL_ONES, $urandom, 1'b1,
                              1'b1));
        // leave recovery with an all-ones threshold, then saturate the window
        send_event(make_event(ACT_ACK, 32'h8001, 32'h9000, $urandom, $urandom, 1'b1, 1'b1));
        repeat (4) send_event(make_event(ACT_ACK, 32'h8001, 32'hA000, $urandom, $urandom, 1'b1,
                                         1'b1));
        send_event(make_event(ACT_HANDSHAKE, $urandom, $urandom, $urandom, 32'd10, 1'b1, 1'b1));
        send_event(make_event(ACT_CONN_START, $urandom, $urandom, $urandom, $urandom, 1'b1,
                              1'b1));
        send_event(make_event(ACT_HANDSHAKE, 32'h8001, $urandom, '0, $urandom, 1'b1, 1'b1));
        send_event(make_event(ACT_ACK, 32'h9000, 32'hA000, $urandom, $urandom, 1'b1, 1'b1));
        wait_for_reports();

        // Random phases, one register setting and idling pattern each
        for (int p = 0; p < NUM_PHASES; p++) begin
            mode = t_idle_mode'(p % 4);
            case (mode)
                IDLE_SENDER: begin
                    tx_idle_pct = 56;
                    rx_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 56;
                end
                IDLE_BOTH: begin
                    tx_idle_pct = 33;
                    rx_stall_pct = 33;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            // upper data bits are junk for the 8-bit threshold
            thr_word = SEG_W'($urandom_range(255) << THR_W) | SEG_W'(phase_thr[p]);
            set_config(phase_seg[p], thr_word);
            if (p == HOLD_PHASE) rx_hold_cycles = HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) wait_for_reports();
                send_event(random_event());
            end
            // long duplicate run to reach the count ceiling
            if (p == STORM_PHASE) begin
                repeat (STORM_LENGTH) send_event(make_event(ACT_ACK, sb.last_ack, $urandom,
                                                            $urandom, $urandom, 1'b1, 1'b1));
            end
            wait_for_reports();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("tcp_congestion_window_control: match");
        end else begin
            $display("tcp_congestion_window_control: mismatch");
        end
        $finish;
    end

endmodule
